[hdl/pcf_pkg.sv]
`default_nettype none

package pcf_pkg;

	// Width at which the value is tested, and the width of the value field.
	localparam int WIDTH      = 32;
	localparam int VALUE_BITS = 32;
	localparam int CNT_W      = $clog2(WIDTH);

	typedef logic [WIDTH-1:0]      word_t;
	typedef logic [WIDTH:0]        wide_t;
	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [CNT_W-1:0]      cnt_t;

	// Trial division constants of the 6k plus or minus 1 walk.
	localparam int FIRST_DIV = 5;
	localparam int DIV_STEP  = 6;
	localparam int PAIR_GAP  = 2;
	localparam int THREE     = 3;

	// Control of one bit-serial remainder lane.
	typedef struct packed {
		logic clear;
		logic shift;
		logic din;
	} rem_ctl_t;

	// Take the value field to the test width, with sign extension when wider.
	function automatic word_t test_word(input value_t raw);
		logic [WIDTH+VALUE_BITS-1:0] ext;
		ext = {{WIDTH{raw[VALUE_BITS-1]}}, raw};
		return ext[WIDTH-1:0];
	endfunction

endpackage

`default_nettype wire

[hdl/prime_classifier_filter.sv]
// Channel  | Handshake                  | Payload
// ---------+----------------------------+------------------------------------
// value    | value_valid, value_stall   | value (32 bit signed)
// result   | result_valid, result_stall | value_out (32 bit signed), is_prime
//
// One item at a time. An item passes the checks of S_CHECK, then for each trial
// divisor pair a pass in S_DIV and a check in S_EVAL (the test by three counts
// as one pair); both divisors of a pair share one bit-serial pass of the two
// remainder lanes. Worst case at WIDTH 32 is a large prime near 2^31: about
// 7700 pairs. Reset clears the sequencer and the result valid flag.
// A finished result waits in the output register, so a stalled result side
// still lets the next item be accepted and tested.
`default_nettype none

module prime_classifier_filter (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                value_valid,
	output logic                     value_stall,
	input  wire logic signed [31:0]  value,
	output logic                     result_valid,
	input  wire logic                result_stall,
	output logic signed [31:0]       value_out,
	output logic                     is_prime
);

	logic            seq_idle;
	logic            seq_done;
	logic            seq_prime;
	logic            accept;
	logic            ack;
	logic            res_valid_q;
	logic            prime_q;
	pcf_pkg::value_t val_q;
	pcf_pkg::value_t out_val_q;

	// An item enters only while the sequencer is free.
	assign value_stall = !seq_idle;
	assign accept      = value_valid && seq_idle;

	// The result register takes a finished item when empty or being drained.
	assign ack = seq_done && (!res_valid_q || !result_stall);

	pcf_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.word   (pcf_pkg::test_word(pcf_pkg::value_t'(value))),
		.ack    (ack),
		.idle   (seq_idle),
		.done   (seq_done),
		.prime  (seq_prime)
	);

	// Hold the value of the item under test.
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q <= pcf_pkg::value_t'(value);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ack) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ack) begin
			out_val_q <= val_q;
			prime_q   <= seq_prime;
		end
	end

	assign result_valid = res_valid_q;
	assign value_out    = signed'(out_val_q);
	assign is_prime     = prime_q;

endmodule

`default_nettype wire

[hdl/pcf_rem_lane.sv]
`default_nettype none

module pcf_rem_lane (
	input  wire logic              clk,
	input  wire pcf_pkg::rem_ctl_t ctl,
	input  wire pcf_pkg::word_t    divisor,
	output pcf_pkg::word_t         rem
);

	pcf_pkg::word_t rem_q;
	pcf_pkg::wide_t trial;

	// Restoring division step: bring in the next dividend bit, subtract if it fits.
	assign trial = {rem_q, ctl.din};

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			rem_q <= '0;
		end else if (ctl.shift) begin
			if (trial >= {1'b0, divisor}) begin
				rem_q <= pcf_pkg::word_t'(trial - {1'b0, divisor});
			end else begin
				rem_q <= trial[pcf_pkg::WIDTH-1:0];
			end
		end
	end

	assign rem = rem_q;

endmodule

`default_nettype wire

[hdl/pcf_seq.sv]
`default_nettype none

module pcf_seq (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire pcf_pkg::word_t word,
	input  wire logic           ack,
	output logic                idle,
	output logic                done,
	output logic                prime
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_TEST,
		S_DIV,
		S_EVAL,
		S_DONE
	} state_t;

	state_t            state_q;
	pcf_pkg::word_t    v_q;
	pcf_pkg::word_t    sh_q;
	pcf_pkg::word_t    i_q;
	pcf_pkg::wide_t    sq_q;
	pcf_pkg::word_t    d0_q;
	pcf_pkg::word_t    d1_q;
	pcf_pkg::cnt_t     cnt_q;
	logic              three_q;
	logic              prime_q;
	pcf_pkg::rem_ctl_t ctl;
	pcf_pkg::word_t    rem0;
	pcf_pkg::word_t    rem1;
	pcf_pkg::wide_t    i_wide;
	pcf_pkg::wide_t    sq_step;

	// Lanes are cleared in the state before a division, then fed MSB first.
	assign ctl.clear = (state_q == S_CHECK) || (state_q == S_TEST);
	assign ctl.shift = (state_q == S_DIV);
	assign ctl.din   = sh_q[pcf_pkg::WIDTH-1];

	pcf_rem_lane u_lane0 (
		.clk     (clk),
		.ctl     (ctl),
		.divisor (d0_q),
		.rem     (rem0)
	);

	pcf_rem_lane u_lane1 (
		.clk     (clk),
		.ctl     (ctl),
		.divisor (d1_q),
		.rem     (rem1)
	);

	// Next square: (i + 6)^2 = i^2 + 12*i + 36.
	assign i_wide  = {1'b0, i_q};
	assign sq_step = (i_wide << 3) + (i_wide << 2)
		+ pcf_pkg::wide_t'(pcf_pkg::DIV_STEP * pcf_pkg::DIV_STEP);

	// Sequencer: small cases, the test by three, then the 6k plus or minus 1 walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			prime_q <= 1'b0;
			three_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						v_q     <= word;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (v_q[pcf_pkg::WIDTH-1]) begin
						prime_q <= 1'b0;
						state_q <= S_DONE;
					end else if (v_q <= pcf_pkg::word_t'(1)) begin
						prime_q <= 1'b0;
						state_q <= S_DONE;
					end else if (v_q <= pcf_pkg::word_t'(pcf_pkg::THREE)) begin
						prime_q <= 1'b1;
						state_q <= S_DONE;
					end else if (!v_q[0]) begin
						prime_q <= 1'b0;
						state_q <= S_DONE;
					end else begin
						d0_q    <= pcf_pkg::word_t'(pcf_pkg::THREE);
						d1_q    <= pcf_pkg::word_t'(pcf_pkg::THREE);
						sh_q    <= v_q;
						cnt_q   <= '0;
						three_q <= 1'b1;
						state_q <= S_DIV;
					end
				end
				S_TEST: begin
					if (sq_q > {1'b0, v_q}) begin
						prime_q <= 1'b1;
						state_q <= S_DONE;
					end else begin
						d0_q    <= i_q;
						d1_q    <= i_q + pcf_pkg::word_t'(pcf_pkg::PAIR_GAP);
						sh_q    <= v_q;
						cnt_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					sh_q  <= sh_q << 1;
					cnt_q <= cnt_q + pcf_pkg::cnt_t'(1);
					if (cnt_q == pcf_pkg::cnt_t'(pcf_pkg::WIDTH - 1)) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (three_q) begin
						three_q <= 1'b0;
						if (rem0 == '0) begin
							prime_q <= 1'b0;
							state_q <= S_DONE;
						end else begin
							i_q     <= pcf_pkg::word_t'(pcf_pkg::FIRST_DIV);
							sq_q    <= pcf_pkg::wide_t'(pcf_pkg::FIRST_DIV
								* pcf_pkg::FIRST_DIV);
							state_q <= S_TEST;
						end
					end else if ((rem0 == '0) || (rem1 == '0)) begin
						prime_q <= 1'b0;
						state_q <= S_DONE;
					end else begin
						i_q     <= i_q + pcf_pkg::word_t'(pcf_pkg::DIV_STEP);
						sq_q    <= sq_q + sq_step;
						state_q <= S_TEST;
					end
				end
				S_DONE: begin
					if (ack) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign idle  = (state_q == S_IDLE);
	assign done  = (state_q == S_DONE);
	assign prime = prime_q;

endmodule

`default_nettype wire
